// ===== rtl/apu_pkg.sv =====
// Shared constants, payload types, state codes and helpers for the AdamW update block.
package apu_pkg;

  localparam int ELEMENT_COUNT = 65536;
  localparam int ADDR_W        = $clog2(ELEMENT_COUNT);
  localparam int DATA_W        = 32;
  localparam int MOM1_W        = 32;
  localparam int MOM2_W        = 48;
  localparam int POW_W         = 25;
  localparam int REG_W         = 24;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int DIV_N_W       = 96;
  localparam int DIV_D_W       = 52;
  localparam int DIV_CNT_W     = $clog2(DIV_N_W);
  localparam int SQRT_IN_W     = 64;
  localparam int SQRT_OUT_W    = 32;
  localparam int SQRT_CNT_W    = $clog2(SQRT_OUT_W);

  localparam logic [POW_W-1:0] ONE_Q24 = POW_W'(1) << 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE     = 8'd0,
    CFG_DECAY_FIRST    = 8'd1,
    CFG_DECAY_SECOND   = 8'd2,
    CFG_STABILITY_TERM = 8'd3,
    CFG_DECAY_WEIGHT   = 8'd4
  } apu_reg_e;

  typedef struct packed {
    logic [15:0]        elem_index;
    logic signed [31:0] param_value;
    logic signed [31:0] grad_value;
    logic               step_end;
  } apu_in_t;

  typedef struct packed {
    logic signed [31:0] new_param;
    logic [15:0]        out_index;
    logic               out_step_end;
  } apu_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  idx;
    logic signed [31:0] param;
    logic signed [31:0] grad;
    logic [31:0]        grad_mag;
    logic               step_end;
  } apu_job_t;

  typedef struct packed {
    logic [REG_W-1:0] learn_rate;
    logic [REG_W-1:0] decay_first;
    logic [REG_W-1:0] decay_second;
    logic [REG_W-1:0] stability_term;
    logic [REG_W-1:0] decay_weight;
  } apu_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MIX1, ST_MIX2, ST_MIX3, ST_STORE, ST_DIVM,
    ST_DIVV, ST_SQRT, ST_RGO, ST_DIVR, ST_WEIGHT, ST_SUM, ST_RATE, ST_FINAL
  } apu_state_e;

  function automatic logic [31:0] abs_s32(input logic signed [31:0] x);
    logic [31:0] neg;
    neg = 32'(-x);
    return x[31] ? neg : 32'(x);
  endfunction

  function automatic logic signed [31:0] sat_s32(input logic signed [41:0] x);
    if (x > 42'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -42'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

// ===== rtl/apu_ram.sv =====
// Generic simple dual-port RAM with registered read.
module apu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/apu_div.sv =====
// Restoring divider, one quotient bit per cycle.
module apu_div import apu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quot
);

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_N_W-1:0]   q;
  logic [DIV_D_W:0]     r;
  logic [DIV_D_W:0]     diff;
  logic                 ge;

  always_comb begin
    r    = {rem, q[DIV_N_W-1]};
    diff = r - {1'b0, dsr};
    ge   = r >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        q      <= dividend;
        dsr    <= divisor;
      end else if (active) begin
        rem <= ge ? diff[DIV_D_W-1:0] : r[DIV_D_W-1:0];
        q   <= {q[DIV_N_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

// ===== rtl/apu_sqrt.sv =====
// Integer square root, one root bit per cycle.
module apu_sqrt import apu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic                  done,
  output logic [SQRT_OUT_W-1:0] root
);

  logic                  active;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [33:0]           rem;
  logic [SQRT_IN_W-1:0]  x;
  logic [35:0]           r;
  logic [35:0]           trial;
  logic [35:0]           diff;
  logic                  ge;

  always_comb begin
    r     = {rem, x[SQRT_IN_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    diff  = r - trial;
    ge    = r >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        root   <= '0;
        x      <= radicand;
      end else if (active) begin
        rem  <= ge ? diff[33:0] : r[33:0];
        root <= {root[SQRT_OUT_W-2:0], ge};
        x    <= {x[SQRT_IN_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_OUT_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/apu_front.sv =====
// Input side: takes items, wraps the index, derives the gradient magnitude, and queues jobs.
module apu_front import apu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  apu_in_t  req,
  input  logic     hold,
  output logic     job_valid,
  input  logic     job_pop,
  output apu_job_t job
);

  apu_job_t          q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              accept;
  apu_job_t          incoming;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH)) | hold;
  assign accept    = push & ~full;
  assign job_valid = count != '0;
  assign job       = q[rd_ptr];

  always_comb begin
    incoming.idx      = req.elem_index[ADDR_W-1:0];
    incoming.param    = req.param_value;
    incoming.grad     = req.grad_value;
    incoming.grad_mag = abs_s32(req.grad_value);
    incoming.step_end = req.step_end;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W + 1)'(accept) - (QPTR_W + 1)'(job_pop);
    end
  end

endmodule

// ===== rtl/apu_back.sv =====
// Execution side: clearing pass after reset, moment update, bias correction, division, root and final update.
module apu_back import apu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  apu_cfg_t cfg,
  input  logic     job_valid,
  input  apu_job_t job,
  output logic     job_pop,
  output logic     clearing,
  input  logic     out_space,
  output logic     res_push,
  output apu_out_t res
);

  localparam logic [DIV_N_W-1:0] VH_CAP    = DIV_N_W'(1) << 62;
  localparam logic [DIV_N_W-1:0] RATIO_CAP = DIV_N_W'(1) << 38;

  apu_state_e state, state_next;

  logic [ADDR_W-1:0]  clr_addr;
  apu_job_t           cur;
  logic [POW_W-1:0]   power_first;
  logic [POW_W-1:0]   power_second;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [MOM1_W-1:0]  m_wdata;
  logic [MOM2_W-1:0]  v_wdata;
  logic [MOM1_W-1:0]  m_rdata;
  logic [MOM2_W-1:0]  v_rdata;

  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quot;
  logic               sqrt_start;
  logic [SQRT_IN_W-1:0] sqrt_in;
  logic               sqrt_done;
  logic [SQRT_OUT_W-1:0] sqrt_root;

  logic signed [56:0] prod_m1;
  logic signed [57:0] prod_m2;
  logic [63:0]        g2_full;
  logic [48:0]        pw1;
  logic [48:0]        pw2;
  logic [MOM2_W-1:0]  v_old;
  logic signed [31:0] m_new;
  logic [MOM2_W-1:0]  g2;
  logic [POW_W-1:0]   pt1;
  logic [POW_W-1:0]   pt2;
  logic [POW_W-1:0]   corr1;
  logic [POW_W-1:0]   corr2;
  logic [47:0]        vp_hi_a;
  logic [48:0]        vp_hi_b;
  logic [47:0]        vp_lo_a;
  logic [48:0]        vp_lo_b;
  logic [MOM2_W-1:0]  v_new;
  logic [55:0]        mh;
  logic [DIV_D_W-1:0] den;
  logic [38:0]        ratio;
  logic signed [56:0] wdp_prod;
  logic signed [39:0] sum;
  logic signed [44:0] lr_hi;
  logic [43:0]        lr_lo;
  logic signed [41:0] upd_now;

  // Combinational helpers for the datapath steps.
  logic signed [58:0] m_acc;
  logic signed [34:0] m_shift;
  logic [49:0]        pt1_acc;
  logic [49:0]        pt2_acc;
  logic [POW_W-1:0]   c2;
  logic [49:0]        v_hi;
  logic [49:0]        v_lo;
  logic [50:0]        v_acc;
  logic [63:0]        vh_capped;
  logic signed [57:0] wdp_acc;
  logic signed [32:0] wdp;
  logic signed [39:0] ratio_signed;
  logic signed [65:0] upd_acc;

  always_comb begin
    m_acc        = 59'(prod_m1) + 59'(prod_m2) + 59'sd8388608;
    m_shift      = 35'(m_acc >>> 24);
    pt1_acc      = 50'(pw1) + 50'd8388608;
    pt2_acc      = 50'(pw2) + 50'd8388608;
    c2           = ONE_Q24 - POW_W'(cfg.decay_second);
    v_hi         = 50'(vp_hi_a) + 50'(vp_hi_b);
    v_lo         = 50'(vp_lo_a) + 50'(vp_lo_b) + 50'd8388608;
    v_acc        = 51'(v_hi) + 51'(v_lo >> 24);
    vh_capped    = (div_quot > VH_CAP) ? VH_CAP[63:0] : div_quot[63:0];
    wdp_acc      = 58'(wdp_prod) + 58'sd8388608;
    wdp          = 33'(wdp_acc >>> 24);
    ratio_signed = m_new[31] ? -$signed({1'b0, ratio}) : $signed({1'b0, ratio});
    upd_acc      = (66'(lr_hi) <<< 20) + $signed({22'b0, lr_lo}) + 66'sd8388608;
  end

  apu_ram #(.WIDTH(MOM1_W), .DEPTH(ELEMENT_COUNT)) u_first (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (m_wdata),
    .raddr (job.idx),
    .rdata (m_rdata)
  );

  apu_ram #(.WIDTH(MOM2_W), .DEPTH(ELEMENT_COUNT)) u_second (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (v_wdata),
    .raddr (job.idx),
    .rdata (v_rdata)
  );

  apu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  apu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    job_pop      = 1'b0;
    clearing     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur.idx;
    m_wdata      = m_new;
    v_wdata      = v_new;
    div_start    = 1'b0;
    div_dividend = {40'b0, abs_s32(m_new), 24'b0};
    div_divisor  = DIV_D_W'(corr1);
    sqrt_start   = 1'b0;
    sqrt_in      = vh_capped;
    res_push     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        m_wdata   = '0;
        v_wdata   = '0;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid && out_space) begin
          job_pop    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_MIX1;
      ST_MIX1:  state_next = ST_MIX2;
      ST_MIX2:  state_next = ST_MIX3;
      ST_MIX3:  state_next = ST_STORE;
      ST_STORE: begin
        ram_we     = 1'b1;
        div_start  = 1'b1;
        state_next = ST_DIVM;
      end
      ST_DIVM: begin
        div_dividend = {24'b0, v_new, 24'b0};
        div_divisor  = DIV_D_W'(corr2);
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIVV;
        end
      end
      ST_DIVV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_RGO;
        end
      end
      ST_RGO: begin
        div_dividend = {mh, 40'b0};
        div_divisor  = den;
        // A zero numerator or a zero denominator is settled without dividing.
        if (mh == '0 || den == '0) begin
          state_next = ST_WEIGHT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_done) begin
          state_next = ST_WEIGHT;
        end
      end
      ST_WEIGHT: state_next = ST_SUM;
      ST_SUM:    state_next = ST_RATE;
      ST_RATE:   state_next = ST_FINAL;
      ST_FINAL: begin
        res_push   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      power_first  <= ONE_Q24;
      power_second <= ONE_Q24;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_FINAL && cur.step_end) begin
        power_first  <= pt1;
        power_second <= pt2;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (job_pop) begin
          cur <= job;
        end
      end
      ST_READ: begin
        prod_m1 <= $signed({1'b0, cfg.decay_first}) * $signed(m_rdata);
        prod_m2 <= $signed({1'b0, ONE_Q24 - POW_W'(cfg.decay_first)}) * cur.grad;
        g2_full <= cur.grad_mag * cur.grad_mag;
        pw1     <= power_first * cfg.decay_first;
        pw2     <= power_second * cfg.decay_second;
        v_old   <= v_rdata;
      end
      ST_MIX1: begin
        m_new <= sat_s32(42'(m_shift));
        g2    <= (g2_full[63:56] != '0) ? '1 : g2_full[55:8];
        pt1   <= POW_W'(pt1_acc >> 24);
        pt2   <= POW_W'(pt2_acc >> 24);
      end
      ST_MIX2: begin
        corr1   <= (pt1 >= ONE_Q24) ? POW_W'(1) : ONE_Q24 - pt1;
        corr2   <= (pt2 >= ONE_Q24) ? POW_W'(1) : ONE_Q24 - pt2;
        vp_hi_a <= v_old[47:24] * cfg.decay_second;
        vp_hi_b <= g2[47:24] * c2;
        vp_lo_a <= v_old[23:0] * cfg.decay_second;
        vp_lo_b <= g2[23:0] * c2;
      end
      ST_MIX3: begin
        v_new <= (v_acc[50:48] != '0) ? '1 : v_acc[47:0];
      end
      ST_DIVM: begin
        if (div_done) begin
          mh <= div_quot[55:0];
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          den <= {sqrt_root, 20'b0} + DIV_D_W'(cfg.stability_term);
        end
      end
      ST_RGO: begin
        ratio <= (mh == '0) ? '0 : RATIO_CAP[38:0];
      end
      ST_DIVR: begin
        if (div_done) begin
          ratio <= (div_quot > RATIO_CAP) ? RATIO_CAP[38:0] : div_quot[38:0];
        end
      end
      ST_WEIGHT: begin
        wdp_prod <= $signed({1'b0, cfg.decay_weight}) * cur.param;
      end
      ST_SUM: begin
        sum <= ratio_signed + 40'(wdp);
      end
      ST_RATE: begin
        lr_hi <= $signed({1'b0, cfg.learn_rate}) * $signed(sum[39:20]);
        lr_lo <= cfg.learn_rate * sum[19:0];
      end
      ST_FINAL: begin
      end
      default: begin
      end
    endcase
  end

  // The final subtract and clamp feed the result item directly.
  assign upd_now = 42'(upd_acc >>> 24);

  always_comb begin
    res.new_param    = sat_s32(42'(cur.param) - upd_now);
    res.out_index    = 16'(cur.idx);
    res.out_step_end = cur.step_end;
  end

  assert property (@(posedge clk) disable iff (rst) clearing |-> !res_push)
    else $error("result produced during the clearing pass");
  assert property (@(posedge clk) disable iff (rst) res_push |-> out_space)
    else $error("result produced with no room in the output queue");
  assert property (@(posedge clk) disable iff (rst) job_pop |=> state == ST_READ)
    else $error("job taken but moment read did not follow");
  assert property (@(posedge clk) disable iff (rst)
    power_first <= ONE_Q24 && power_second <= ONE_Q24)
    else $error("beta power grew above one");

endmodule

// ===== rtl/adamw_param_update.sv =====
// Top level of the AdamW parameter update block: configuration registers and result queue.
//
// Each item is one element: its index, parameter and gradient. The block keeps first and
// second moments for 65536 elements in two RAMs and returns the updated parameter, in
// arrival order. Items are processed one at a time through the shared restoring divider,
// used up to three times per item (bias-corrected first moment, bias-corrected second
// moment, update ratio), and the square-root unit. Up to four items wait in the input
// queue and two results in the output queue. After reset a clearing pass zeroes all
// 65536 entries of both moment RAMs, with full held high; configuration writes are taken
// at any time and should be made while the block is idle.
module adamw_param_update import apu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  apu_in_t               req,
  output logic                  empty,
  input  logic                  pop,
  output apu_out_t              rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  apu_cfg_t cfg;
  logic     job_valid;
  logic     job_pop;
  apu_job_t job;
  logic     clearing;
  logic     out_space;
  logic     res_push;
  apu_out_t res;

  apu_out_t oq [2];
  logic     owr;
  logic     ord;
  logic [1:0] ocount;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate     <= 24'd16777;
      cfg.decay_first    <= 24'd15099494;
      cfg.decay_second   <= 24'd16760438;
      cfg.stability_term <= 24'd10995;
      cfg.decay_weight   <= 24'd167772;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARN_RATE:     cfg.learn_rate     <= cfg_data[REG_W-1:0];
        CFG_DECAY_FIRST:    cfg.decay_first    <= cfg_data[REG_W-1:0];
        CFG_DECAY_SECOND:   cfg.decay_second   <= cfg_data[REG_W-1:0];
        CFG_STABILITY_TERM: cfg.stability_term <= cfg_data[REG_W-1:0];
        CFG_DECAY_WEIGHT:   cfg.decay_weight   <= cfg_data[REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .hold      (clearing),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  apu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .clearing  (clearing),
    .out_space (out_space),
    .res_push  (res_push),
    .res       (res)
  );

  // Two-entry result queue; only one item is in flight, so one free slot is enough.
  assign empty     = ocount == 2'd0;
  assign out_space = ocount != 2'd2;
  assign rsp       = oq[ord];

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[owr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (res_push) begin
        owr <= ~owr;
      end
      if (pop && !empty) begin
        ord <= ~ord;
      end
      ocount <= ocount + 2'(res_push) - 2'(pop && !empty);
    end
  end

endmodule
